// ===== rtl/tkbt_pkg.sv =====
// Package for the touch key baseline tracker: widths, register map, types
// and the priority search used by the latch stage.
// No dependencies.
`default_nettype none

package tkbt_pkg;

   localparam int NUM_KEYS      = 16;
   localparam int KEY_W         = 4;
   localparam int TIME_W        = 16;
   localparam int RATIO_W       = 10;
   localparam int PROD_W        = TIME_W + RATIO_W;
   localparam int FRAC_W        = 8;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 4;

   localparam logic [TIME_W-1:0]  BASELINE_INIT = 16'hFFFF;
   localparam logic [TIME_W-1:0]  MAX16         = 16'hFFFF;
   localparam logic [TIME_W-1:0]  LEAK_PERIOD_RST    = 16'd1000;
   localparam logic [TIME_W-1:0]  DEBOUNCE_LIMIT_RST = 16'd10;
   localparam logic [RATIO_W-1:0] PRESS_RATIO_RST    = 10'd294;
   localparam logic [KEY_W-1:0]   LATCHED_KEY_RST    = 4'd15;

   typedef enum logic [1:0] {
      REG_LEAK_PERIOD    = 2'd0,
      REG_DEBOUNCE_LIMIT = 2'd1,
      REG_PRESS_RATIO    = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [TIME_W-1:0]  leak_period;
      logic [TIME_W-1:0]  debounce_limit;
      logic [RATIO_W-1:0] press_ratio;
   } cfg_type;

   typedef struct packed {
      logic             update;
      logic             key_valid;
      logic [KEY_W-1:0] key;
      logic             pressed;
   } latch_req_type;

   typedef struct packed {
      logic             new_key;
      logic [KEY_W-1:0] hot_key;
      logic             key_latched;
   } latch_rsp_type;

   // Index of the lowest set flag (highest priority key); zero when none set.
   function automatic logic [KEY_W-1:0] lowest_set(input logic [NUM_KEYS-1:0] flags);
      logic [KEY_W-1:0] idx;
      idx = '0;
      for (int i = NUM_KEYS - 1; i >= 0; i--) begin
         if (flags[i]) begin
            idx = KEY_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/tkbt_if.sv =====
// Valid/ready channel interfaces for measurement requests and results.
// Depends on tkbt_pkg.
`default_nettype none

interface tkbt_req_if
   import tkbt_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [KEY_W-1:0]  key_index;
   logic [TIME_W-1:0] fall_time;

   modport source (output valid, output key_index, output fall_time, input ready);
   modport sink   (input valid, input key_index, input fall_time, output ready);
endinterface

interface tkbt_rsp_if
   import tkbt_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic              key_pressed;
   logic              new_key;
   logic [KEY_W-1:0]  hot_key;
   logic              key_latched;
   logic [TIME_W-1:0] baseline;

   modport source (output valid, output key_pressed, output new_key, output hot_key,
                   output key_latched, output baseline, input ready);
   modport sink   (input valid, input key_pressed, input new_key, input hot_key,
                   input key_latched, input baseline, output ready);
endinterface

`default_nettype wire

// ===== rtl/tkbt_csr.sv =====
// APB-style configuration registers: leak period, debounce limit, press ratio.
// Depends on tkbt_pkg.
`default_nettype none

module tkbt_csr
   import tkbt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   cfg_type       cfg_ff;
   reg_index_type sel;
   logic          wr_en;

   assign sel        = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leak_period    <= LEAK_PERIOD_RST;
         cfg_ff.debounce_limit <= DEBOUNCE_LIMIT_RST;
         cfg_ff.press_ratio    <= PRESS_RATIO_RST;
      end else if (wr_en) begin
         case (sel)
            REG_LEAK_PERIOD:    cfg_ff.leak_period    <= csr_pwdata[TIME_W-1:0];
            REG_DEBOUNCE_LIMIT: cfg_ff.debounce_limit <= csr_pwdata[TIME_W-1:0];
            REG_PRESS_RATIO:    cfg_ff.press_ratio    <= csr_pwdata[RATIO_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (sel)
         REG_LEAK_PERIOD:    csr_prdata = CSR_DATA_W'(cfg_ff.leak_period);
         REG_DEBOUNCE_LIMIT: csr_prdata = CSR_DATA_W'(cfg_ff.debounce_limit);
         REG_PRESS_RATIO:    csr_prdata = CSR_DATA_W'(cfg_ff.press_ratio);
         default:            csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/tkbt_latch.sv =====
// Priority key latch: per-key down flags, held key and debounce counter.
// Depends on tkbt_pkg.
`default_nettype none

module tkbt_latch
   import tkbt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire latch_req_type     req,
   input  wire logic [TIME_W-1:0] debounce_limit,
   output latch_rsp_type          rsp
);

   logic [NUM_KEYS-1:0] down_ff, down_in;
   logic                held_ff, held_in;
   logic [TIME_W-1:0]   dbc_ff, dbc_in;
   logic [KEY_W-1:0]    hot_ff, hot_in;
   logic                new_key;

   always_comb begin
      down_in = down_ff;
      held_in = held_ff;
      dbc_in  = dbc_ff;
      hot_in  = hot_ff;
      new_key = 1'b0;
      if (req.key_valid) begin
         down_in[req.key] = req.pressed;
         if (!held_ff) begin
            if (|down_in) begin
               held_in = 1'b1;
               hot_in  = lowest_set(down_in);
               new_key = 1'b1;
            end
         end else if (dbc_ff != MAX16) begin
            dbc_in = dbc_ff + 1'b1;
         end
         // release once debounced and every key is up
         if ((dbc_in > debounce_limit) && (down_in == '0)) begin
            held_in = 1'b0;
            dbc_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         down_ff <= '0;
         held_ff <= 1'b0;
         dbc_ff  <= '0;
         hot_ff  <= LATCHED_KEY_RST;
      end else if (req.update) begin
         down_ff <= down_in;
         held_ff <= held_in;
         dbc_ff  <= dbc_in;
         hot_ff  <= hot_in;
      end
   end

   assign rsp.new_key     = new_key;
   assign rsp.hot_key     = hot_in;
   assign rsp.key_latched = held_in;

endmodule

`default_nettype wire

// ===== rtl/touch_key_baseline_tracker_unit.sv =====
// Top level of the touch key baseline tracker: datapath, baseline/leak stores.
// Depends on tkbt_pkg, tkbt_if, tkbt_csr and tkbt_latch.
`default_nettype none

// Usage:
//   req_chan carries one fall-time measurement per transaction (key_index,
//   fall_time); rsp_chan returns exactly one result transaction per request,
//   in order. Both are valid/ready channels.
//   Datapath: input register, then one combinational pass (store read,
//   minimum, leak timer, baseline * press_ratio, press test, priority
//   latch) into the result register. One transaction is taken per cycle
//   while the receiver is ready. The per-key stores and the latch update at
//   the edge that loads the result register, so back-to-back requests to
//   the same key see the updated state.
//   When the receiver stalls, hold the result register; the input register
//   takes one more transaction and then ready drops until the result moves.
//   The csr_ APB port writes leak_period, debounce_limit and press_ratio;
//   write only while no transaction is in flight.
//   Synchronous reset empties both registers, sets every baseline to its
//   initial value, clears leak timers, down flags and the latch, and
//   restores the register defaults.
module touch_key_baseline_tracker_unit
   import tkbt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   tkbt_req_if.sink                   req_chan,
   tkbt_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type cfg;

   tkbt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Register valid flags and load strobes
   logic v0_ff, vo_ff;
   logic v0_in, vo_in;
   logic ld0, ldo;

   assign ldo = v0_ff & (~vo_ff | rsp_chan.ready);
   assign req_chan.ready = ~v0_ff | ldo;
   assign ld0 = req_chan.valid & req_chan.ready;

   assign v0_in = ld0 | (v0_ff & ~ldo);
   assign vo_in = ldo | (vo_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         vo_ff <= vo_in;
      end
   end

   // Input register
   logic [KEY_W-1:0]  p0_key_ff;
   logic [TIME_W-1:0] p0_time_ff;

   always_ff @(posedge clock) begin
      if (ld0) begin
         p0_key_ff  <= req_chan.key_index;
         p0_time_ff <= req_chan.fall_time;
      end
   end

   // Baseline update: follow the minimum, then apply the leak timer
   logic [TIME_W-1:0] base_store_ff [NUM_KEYS];
   logic [TIME_W-1:0] leak_store_ff [NUM_KEYS];
   logic              p0_valid_key;
   logic [TIME_W-1:0] base_rd, leak_rd, base_in, leak_in;

   assign p0_valid_key = (32'(p0_key_ff) < 32'(NUM_KEYS));
   assign base_rd      = base_store_ff[p0_key_ff];
   assign leak_rd      = leak_store_ff[p0_key_ff];

   always_comb begin
      base_in = (p0_time_ff < base_rd) ? p0_time_ff : base_rd;
      leak_in = leak_rd;
      if (leak_rd > cfg.leak_period) begin
         if (base_in != MAX16) begin
            base_in = base_in + 1'b1;
         end
         leak_in = '0;
      end else if (leak_rd != MAX16) begin
         leak_in = leak_rd + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_KEYS; i++) begin
            base_store_ff[i] <= BASELINE_INIT;
            leak_store_ff[i] <= '0;
         end
      end else if (ldo && p0_valid_key) begin
         base_store_ff[p0_key_ff] <= base_in;
         leak_store_ff[p0_key_ff] <= leak_in;
      end
   end

   // Press test: fall_time scaled to Q16.8 against baseline * ratio (ratio in Q2.8)
   logic [PROD_W-1:0] thresh;
   logic              pressed;
   latch_req_type     lreq;
   latch_rsp_type     lrsp;

   assign thresh  = PROD_W'(base_in) * PROD_W'(cfg.press_ratio);
   assign pressed = p0_valid_key &
                    (PROD_W'({p0_time_ff, {FRAC_W{1'b0}}}) > thresh);

   assign lreq.update    = ldo;
   assign lreq.key_valid = p0_valid_key;
   assign lreq.key       = p0_key_ff;
   assign lreq.pressed   = pressed;

   tkbt_latch u_latch (
      .clock          (clock),
      .reset          (reset),
      .req            (lreq),
      .debounce_limit (cfg.debounce_limit),
      .rsp            (lrsp)
   );

   // Result register
   logic              o_pressed_ff, o_new_ff, o_latched_ff;
   logic [KEY_W-1:0]  o_hot_ff;
   logic [TIME_W-1:0] o_base_ff;

   always_ff @(posedge clock) begin
      if (ldo) begin
         o_pressed_ff <= pressed;
         o_new_ff     <= lrsp.new_key;
         o_hot_ff     <= lrsp.hot_key;
         o_latched_ff <= lrsp.key_latched;
         // drop the baseline for an ignored key
         o_base_ff    <= p0_valid_key ? base_in : '0;
      end
   end

   assign rsp_chan.valid       = vo_ff;
   assign rsp_chan.key_pressed = o_pressed_ff;
   assign rsp_chan.new_key     = o_new_ff;
   assign rsp_chan.hot_key     = o_hot_ff;
   assign rsp_chan.key_latched = o_latched_ff;
   assign rsp_chan.baseline    = o_base_ff;

endmodule

`default_nettype wire
